>>> rtl/core/ktt_pkg.sv
// Shared types and constants for the keyed one-shot timer table.
package ktt_pkg;

    // Table geometry and field widths
    localparam int MAX_TASKS = 16;
    localparam int KEY_W     = 16;
    localparam int TIME_W    = 48;
    localparam int DELAY_W   = 32;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;

    // Beat layout on the two stream sides
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_SCHEDULE = 3'd1,
        CMD_CANCEL   = 3'd2,
        CMD_IS_DUE   = 3'd3,
        CMD_POLL     = 3'd4,
        CMD_CLEAR    = 3'd5
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic tick;
        logic sched;
        logic cancel;
        logic clear;
        logic poll_start;
        logic poll_pop;
        logic out_load;
    } t_dp_ctl;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic out_free;
        logic any_due;
        logic pop_last;
    } t_dp_stat;

endpackage

>>> rtl/core/keyed_one_shot_timer_table.sv
// Top level: keyed one-shot timer table with stream command and result sides.
// A result is loaded into the output register in the execute state once that
// register is free; a poll with due timers loads them in the poll state instead,
// one per cycle while the output is free. A command is accepted only once the
// last is done; one finished result may wait while the next command is accepted.
// Synchronous active-low reset empties the table and zeroes the time.
module keyed_one_shot_timer_table
    import ktt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // cmd[2:0], task_key[18:3], delay[50:19], zero pad above
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // result_key[15:0], answer[16], status[18:17], pending_count[23:19]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    ktt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_ctl           (ctl)
    );

    ktt_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

>>> rtl/core/ktt_dpath.sv
// Datapath: timer cells with parallel key match, tick counter and output register.
module ktt_dpath
    import ktt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_ctl               i_ctl,
    output t_dp_stat              o_stat,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast
);

    // Latched command beat
    t_cmd                      r_cmd;
    logic [KEY_W-1:0]          r_key;
    logic signed [DELAY_W-1:0] r_delay;

    // Timer cells and counters
    logic [KEY_W-1:0]  r_keys [MAX_TASKS];
    logic [TIME_W-1:0] r_dues [MAX_TASKS];
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_now;
    logic [MAX_TASKS-1:0] r_mask;

    // Output register
    logic                  r_out_valid;
    logic [KEY_W-1:0]      r_out_key;
    logic                  r_out_answer;
    t_status               r_out_status;
    logic [CNT_W-1:0]      r_out_count;
    logic                  r_out_last;

    logic [MAX_TASKS-1:0] valid;
    logic [MAX_TASKS-1:0] match;
    logic [MAX_TASKS-1:0] due_mask;
    logic                 found;
    logic                 full;
    logic [IDX_W-1:0]     match_idx;
    logic [IDX_W-1:0]     pop_idx;
    logic [TIME_W-1:0]    due_sel;
    logic [TIME_W-1:0]    delay_ext;
    logic [TIME_W:0]      due_sum;
    logic [TIME_W-1:0]    sched_due;
    logic [CNT_W-1:0]     due_cnt;
    logic [MAX_TASKS-1:0] mask_left;
    logic                 shift_en;
    logic [IDX_W-1:0]     shift_pos;

    logic [KEY_W-1:0] n_out_key;
    logic             n_out_answer;
    t_status          n_out_status;
    logic [CNT_W-1:0] n_out_count;
    logic             n_out_last;

    // Match all cells against the latched key and against the current time
    always_comb begin
        match_idx = '0;
        pop_idx   = '0;
        due_sel   = '0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            valid[i]    = (CNT_W'(i) < r_count);
            match[i]    = valid[i] && (r_keys[i] == r_key);
            due_mask[i] = valid[i] && (r_now >= r_dues[i]);
            if (match[i]) begin
                match_idx = match_idx | IDX_W'(i);
                due_sel   = due_sel | r_dues[i];
            end
            if (r_mask[i]) begin
                pop_idx = IDX_W'(i);
            end
        end
    end

    assign found     = |match;
    assign full      = (r_count >= CNT_W'(MAX_TASKS));
    assign due_cnt   = CNT_W'($countones(due_mask));
    assign mask_left = r_mask & ~(MAX_TASKS'(1) << pop_idx);

    // Saturating due time for schedule; a negative delay counts as zero
    assign delay_ext = r_delay[DELAY_W-1] ? '0
                     : {{(TIME_W-DELAY_W){1'b0}}, r_delay};
    assign due_sum   = {1'b0, r_now} + {1'b0, delay_ext};
    assign sched_due = due_sum[TIME_W] ? TIME_MAX : due_sum[TIME_W-1:0];

    assign shift_en  = (i_ctl.cancel && found) || i_ctl.poll_pop;
    assign shift_pos = i_ctl.poll_pop ? pop_idx : match_idx;

    assign o_stat.cmd      = r_cmd;
    assign o_stat.out_free = !r_out_valid || i_m_axis_tready;
    assign o_stat.any_due  = |due_mask;
    assign o_stat.pop_last = (mask_left == '0);

    // Build the next result beat
    always_comb begin
        n_out_key    = r_key;
        n_out_answer = 1'b0;
        n_out_status = ST_OK;
        n_out_count  = r_count;
        n_out_last   = 1'b1;
        if (i_ctl.poll_pop) begin
            n_out_key    = r_keys[pop_idx];
            n_out_answer = 1'b1;
            n_out_last   = (mask_left == '0);
        end else begin
            case (r_cmd)
                CMD_SCHEDULE: begin
                    if (!found && full) begin
                        n_out_status = ST_FULL;
                    end else if (!found) begin
                        n_out_count = r_count + CNT_W'(1);
                    end
                end
                CMD_CANCEL: begin
                    n_out_answer = found;
                    n_out_status = found ? ST_OK : ST_NOT_FOUND;
                    if (found) begin
                        n_out_count = r_count - CNT_W'(1);
                    end
                end
                CMD_IS_DUE: begin
                    n_out_answer = found && (r_now >= due_sel);
                    n_out_status = found ? ST_OK : ST_NOT_FOUND;
                end
                CMD_CLEAR: begin
                    n_out_count = '0;
                end
                default: begin
                    n_out_count = r_count;
                end
            endcase
        end
    end

    // Latch the input beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd   <= t_cmd'(i_s_axis_tdata[CMD_W-1:0]);
            r_key   <= i_s_axis_tdata[CMD_W +: KEY_W];
            r_delay <= i_s_axis_tdata[CMD_W+KEY_W +: DELAY_W];
        end
    end

    // Update cell contents: shift down on removal, write on schedule
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int i = 0; i < MAX_TASKS - 1; i++) begin
                if (IDX_W'(i) >= shift_pos) begin
                    r_keys[i] <= r_keys[i+1];
                    r_dues[i] <= r_dues[i+1];
                end
            end
        end else if (i_ctl.sched) begin
            if (found) begin
                r_dues[match_idx] <= sched_due;
            end else if (!full) begin
                r_keys[r_count[IDX_W-1:0]] <= r_key;
                r_dues[r_count[IDX_W-1:0]] <= sched_due;
            end
        end
    end

    // Hold the due mask for a poll sweep
    always_ff @(posedge i_clk) begin
        if (i_ctl.poll_start) begin
            r_mask <= due_mask;
        end else if (i_ctl.poll_pop) begin
            r_mask <= mask_left;
        end
    end

    // Entry count and tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_now   <= '0;
        end else begin
            if (i_ctl.tick && (r_now != TIME_MAX)) begin
                r_now <= r_now + TIME_W'(1);
            end
            if (i_ctl.clear) begin
                r_count <= '0;
            end else if (i_ctl.cancel && found) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_ctl.sched && !found && !full) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_ctl.poll_start) begin
                r_count <= r_count - due_cnt;
            end
        end
    end

    // Output register: load a beat, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_key    <= n_out_key;
            r_out_answer <= n_out_answer;
            r_out_status <= n_out_status;
            r_out_count  <= n_out_count;
            r_out_last   <= n_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {r_out_count, r_out_status, r_out_answer, r_out_key};

endmodule

>>> rtl/core/ktt_ctrl.sv
// Controller: sequences each command through the timer datapath.
module ktt_ctrl
    import ktt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    output logic     o_s_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POLL
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_axis_tready = (r_state == S_IDLE);

    // Decode the next state and the datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.cmd) inside
                    CMD_TICK: begin
                        o_ctl.tick = 1'b1;
                        n_state    = S_IDLE;
                    end
                    CMD_SCHEDULE, CMD_CANCEL, CMD_IS_DUE, CMD_CLEAR: begin
                        if (i_stat.out_free) begin
                            o_ctl.sched    = (i_stat.cmd == CMD_SCHEDULE);
                            o_ctl.cancel   = (i_stat.cmd == CMD_CANCEL);
                            o_ctl.clear    = (i_stat.cmd == CMD_CLEAR);
                            o_ctl.out_load = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    CMD_POLL: begin
                        if (i_stat.any_due) begin
                            o_ctl.poll_start = 1'b1;
                            n_state          = S_POLL;
                        end else if (i_stat.out_free) begin
                            o_ctl.out_load = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_POLL: begin
                if (i_stat.out_free) begin
                    o_ctl.poll_pop = 1'b1;
                    o_ctl.out_load = 1'b1;
                    if (i_stat.pop_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sim/tb_keyed_one_shot_timer_table.sv
// Self-checking stream testbench for the keyed one-shot timer table.
module tb_keyed_one_shot_timer_table
    import ktt_pkg::*;
();

    // Unused command codes, which the block must ignore
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
    localparam int POOL_N      = 24;
    localparam int RAND_ITEMS  = 370;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic             answer;
        t_status          status;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_timer_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  m_ready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    // Commands waiting to be sent, and results the table should produce
    logic [IN_DATA_W-1:0]  cmd_q [$];
    t_timer_result         result_q [$];
    logic [KEY_W-1:0]      key_pool [POOL_N];
    int                    n_items = 0;
    int                    n_sent = 0;
    int                    n_results = 0;
    int                    fail_count = 0;
    int                    send_gap = 0;
    int                    recv_gap = 0;
    int                    hold_left = 0;
    logic                  hold_done = 1'b0;

    // Shadow copy of the timer table
    logic [TIME_W-1:0]     tbl_now = '0;
    logic [KEY_W-1:0]      tbl_key [MAX_TASKS];
    logic [TIME_W-1:0]     tbl_due [MAX_TASKS];
    int                    tbl_cnt = 0;

    keyed_one_shot_timer_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Queue one command beat; spare codes do not count as real items
    function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                    logic [DELAY_W-1:0] delay);
        cmd_q.push_back({{(IN_DATA_W-CMD_W-KEY_W-DELAY_W){1'b0}}, delay, key, cmd});
        if (cmd != CMD_SPARE6 && cmd != CMD_SPARE7) n_items++;
    endfunction

    // Mostly keys from the pool so that lookups hit, now and then any key
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 7) == 0) return KEY_W'($urandom);
        return key_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    // Mostly short delays, plus negative, huge and fully random ones
    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return DELAY_W'($urandom_range(0, 20));
        if (r < 65) return {1'b1, 31'($urandom)};
        if (r < 75) return DELAY_W'($urandom);
        if (r < 80) return 32'h7FFF_FFFF;
        if (r < 85) return 32'h8000_0000;
        return DELAY_W'($urandom_range(0, 100));
    endfunction

    // Idle length: mostly none or short, a few long, none inside steady windows
    function automatic int pick_gap(int beats);
        int r;
        if ((beats / 40) % 4 == 2) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic int find_newest(logic [KEY_W-1:0] key);
        for (int i = tbl_cnt - 1; i >= 0; i--)
            if (tbl_key[i] == key) return i;
        return -1;
    endfunction

    // Drop one entry and close the gap, keeping age order
    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < tbl_cnt; i++) begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_due[i] = tbl_due[i + 1];
        end
        tbl_cnt--;
    endfunction

    function automatic void push_result(logic [KEY_W-1:0] key, logic answer, t_status status,
                                        logic last);
        t_timer_result r;
        r.key    = key;
        r.answer = answer;
        r.status = status;
        r.count  = CNT_W'(tbl_cnt);
        r.last   = last;
        result_q.push_back(r);
    endfunction

    // Advance the shadow table by one accepted command and queue its results
    function automatic void apply_cmd(logic [IN_DATA_W-1:0] beat);
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        logic [DELAY_W-1:0] delay;
        logic [TIME_W-1:0]  span;
        logic [TIME_W-1:0]  due;
        logic [KEY_W-1:0]   fired [$];
        int                 pos;
        cmd   = beat[CMD_W-1:0];
        key   = beat[CMD_W+KEY_W-1:CMD_W];
        delay = beat[CMD_W+KEY_W+DELAY_W-1:CMD_W+KEY_W];
        case (cmd)
            CMD_TICK: begin
                if (tbl_now != TIME_MAX) tbl_now = tbl_now + 1'b1;
            end
            CMD_SCHEDULE: begin
                span = delay[DELAY_W-1] ? '0 : TIME_W'(delay);
                due  = (span > TIME_MAX - tbl_now) ? TIME_MAX : tbl_now + span;
                pos  = find_newest(key);
                if (pos >= 0) begin
                    tbl_due[pos] = due;
                    push_result(key, 1'b0, ST_OK, 1'b1);
                end else if (tbl_cnt >= MAX_TASKS) begin
                    push_result(key, 1'b0, ST_FULL, 1'b1);
                end else begin
                    tbl_key[tbl_cnt] = key;
                    tbl_due[tbl_cnt] = due;
                    tbl_cnt++;
                    push_result(key, 1'b0, ST_OK, 1'b1);
                end
            end
            CMD_CANCEL: begin
                pos = find_newest(key);
                if (pos >= 0) begin
                    drop_entry(pos);
                    push_result(key, 1'b1, ST_OK, 1'b1);
                end else begin
                    push_result(key, 1'b0, ST_NOT_FOUND, 1'b1);
                end
            end
            CMD_IS_DUE: begin
                pos = find_newest(key);
                if (pos >= 0) push_result(key, tbl_now >= tbl_due[pos], ST_OK, 1'b1);
                else push_result(key, 1'b0, ST_NOT_FOUND, 1'b1);
            end
            CMD_POLL: begin
                // Collect expired timers newest first; counts reflect all removals
                for (int i = tbl_cnt - 1; i >= 0; i--) begin
                    if (tbl_now >= tbl_due[i]) begin
                        fired.push_back(tbl_key[i]);
                        drop_entry(i);
                    end
                end
                if (fired.size() == 0) push_result(key, 1'b0, ST_OK, 1'b1);
                foreach (fired[k])
                    push_result(fired[k], 1'b1, ST_OK, k == fired.size() - 1);
            end
            CMD_CLEAR: begin
                tbl_cnt = 0;
                push_result(key, 1'b0, ST_OK, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // Driver: offer queued beats with random idle gaps
    always @(posedge i_clk) begin
        logic                 nv;
        logic [IN_DATA_W-1:0] nd;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            nv = s_valid;
            nd = s_data;
            if (s_valid && o_s_axis_tready) begin
                apply_cmd(s_data);
                void'(cmd_q.pop_front());
                n_sent++;
                nv = 1'b0;
                send_gap = pick_gap(n_sent);
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (cmd_q.size() != 0) begin
                    nv = 1'b1;
                    nd = cmd_q[0];
                end
            end
            s_valid <= nv;
            s_data  <= nd;
        end
    end

    // Hold off the result side once for a long stretch so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && n_results >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: take result beats and check them against the oldest expectation
    always @(posedge i_clk) begin
        t_timer_result    want;
        logic [KEY_W-1:0] got_key;
        logic             got_ans;
        logic [1:0]       got_st;
        logic [CNT_W-1:0] got_cnt;
        logic             nr;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            nr = m_ready;
            if (o_m_axis_tvalid && m_ready) begin
                got_key = o_m_axis_tdata[KEY_W-1:0];
                got_ans = o_m_axis_tdata[KEY_W];
                got_st  = o_m_axis_tdata[KEY_W+STAT_W:KEY_W+1];
                got_cnt = o_m_axis_tdata[KEY_W+STAT_W+CNT_W:KEY_W+STAT_W+1];
                n_results <= n_results + 1;
                if (result_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat: key=%h ans=%b st=%0d cnt=%0d last=%b",
                                 got_key, got_ans, got_st, got_cnt, o_m_axis_tlast);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (got_key !== want.key || got_ans !== want.answer ||
                        got_st !== want.status || got_cnt !== want.count ||
                        o_m_axis_tlast !== want.last) begin
                        if (fail_count < 10)
                            $display("result mismatch: expected key=%h ans=%b st=%0d cnt=%0d last=%b, got key=%h ans=%b st=%0d cnt=%0d last=%b",
                                     want.key, want.answer, want.status, want.count,
                                     want.last, got_key, got_ans, got_st, got_cnt,
                                     o_m_axis_tlast);
                        fail_count++;
                    end
                end
                recv_gap = pick_gap(n_results);
            end
            if (hold_left > 0) begin
                nr = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                nr = 1'b0;
            end else if (nr && !o_m_axis_tvalid && $urandom_range(0, 9) == 0) begin
                nr = 1'b0;
            end else begin
                nr = 1'b1;
            end
            m_ready <= nr;
        end
    end

    // Build the stimulus, release reset, wait for the drain and report
    initial begin
        int kind;
        int reps;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_N; i++) key_pool[i] = {11'($urandom), 5'(i)};

        // Directed: saturating delays, re-arm, lookups that miss, polls, spare codes, clear
        add_cmd(CMD_TICK, key_pool[3], '0);
        add_cmd(CMD_SCHEDULE, key_pool[0], 32'h8000_0000);
        add_cmd(CMD_SCHEDULE, key_pool[1], 32'h7FFF_FFFF);
        add_cmd(CMD_SCHEDULE, key_pool[2], 32'd3);
        add_cmd(CMD_SCHEDULE, key_pool[0], 32'd5);
        add_cmd(CMD_IS_DUE, key_pool[0], '0);
        add_cmd(CMD_IS_DUE, key_pool[1], '0);
        add_cmd(CMD_IS_DUE, key_pool[5], '0);
        add_cmd(CMD_CANCEL, key_pool[5], '0);
        add_cmd(CMD_CANCEL, key_pool[1], '1);
        add_cmd(CMD_POLL, key_pool[6], '0);
        repeat (5) add_cmd(CMD_TICK, KEY_W'($urandom), DELAY_W'($urandom));
        add_cmd(CMD_IS_DUE, key_pool[0], '0);
        add_cmd(CMD_POLL, key_pool[7], '0);
        add_cmd(CMD_POLL, key_pool[8], '0);
        add_cmd(CMD_SPARE6, KEY_W'($urandom), DELAY_W'($urandom));
        add_cmd(CMD_SPARE7, '1, '1);
        add_cmd(CMD_SCHEDULE, key_pool[3], 32'hFFFF_FFFF);
        add_cmd(CMD_CLEAR, key_pool[9], '0);
        add_cmd(CMD_IS_DUE, key_pool[3], '0);

        // Random: fill-to-overflow runs, tick runs ending in a poll, single commands
        while (n_items < RAND_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                for (int j = 0; j < MAX_TASKS + 2; j++)
                    add_cmd(CMD_SCHEDULE, key_pool[j], DELAY_W'($urandom_range(0, 40)));
                add_cmd(CMD_SCHEDULE, key_pool[$urandom_range(0, MAX_TASKS - 1)],
                        pick_delay());
            end else if (kind < 30) begin
                reps = $urandom_range(1, 12);
                repeat (reps) add_cmd(CMD_TICK, pick_key(), pick_delay());
                add_cmd(CMD_POLL, pick_key(), pick_delay());
            end else if (kind < 33) begin
                add_cmd($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7, pick_key(),
                        pick_delay());
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 35) add_cmd(CMD_SCHEDULE, pick_key(), pick_delay());
                else if (kind < 50) add_cmd(CMD_CANCEL, pick_key(), pick_delay());
                else if (kind < 70) add_cmd(CMD_IS_DUE, pick_key(), pick_delay());
                else if (kind < 85) add_cmd(CMD_POLL, pick_key(), pick_delay());
                else if (kind < 96) add_cmd(CMD_TICK, pick_key(), pick_delay());
                else add_cmd(CMD_CLEAR, pick_key(), pick_delay());
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_q.size() != 0 || s_valid) @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && result_q.size() == 0) begin
            $display("tb_keyed_one_shot_timer_table OK");
        end else begin
            $display("tb_keyed_one_shot_timer_table NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #12000000;
        $display("tb_keyed_one_shot_timer_table NOT OK");
        $finish;
    end

endmodule
